// ----- rtl/sdbi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdbi_pkg
// Shared types and constants for the sequence database index parser.
// ----------------------------------------------------------------------------
package sdbi_pkg;

    // Parse phases, in file order
    typedef enum logic [3:0] {
        PH_VERSION,
        PH_TYPE,
        PH_VOLUME,
        PH_STRLEN,
        PH_STRBODY,
        PH_COUNT,
        PH_RESIDUES,
        PH_MAXLEN,
        PH_HDRTAB,
        PH_SEQTAB
    } t_phase;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_VERSION   = 3'd0,
        KIND_VOLUME    = 3'd1,
        KIND_COUNT     = 3'd2,
        KIND_RESIDUES  = 3'd3,
        KIND_MAXLEN    = 3'd4,
        KIND_OFFSET    = 3'd5,
        KIND_STATUS    = 3'd6
    } t_kind;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_VERSION = 3'd1,
        ST_TRUNC_HDR   = 3'd2,
        ST_TABLES_INC  = 3'd3,
        ST_CORRUPT     = 3'd4,
        ST_NOT_PROTEIN = 3'd5
    } t_status;

    // File format constants
    localparam logic [63:0] VERSION_FOUR = 64'd4;
    localparam logic [63:0] VERSION_FIVE = 64'd5;
    localparam logic [63:0] TYPE_PROTEIN = 64'd1;
    localparam logic [1:0]  STRINGS_V4   = 2'd2;
    localparam logic [1:0]  STRINGS_V5   = 2'd3;
    localparam logic [2:0]  LAST_BYTE_W4 = 3'd3;   // last byte of a 32-bit field
    localparam logic [2:0]  LAST_BYTE_W8 = 3'd7;   // last byte of a 64-bit field

    // Result queue depth (holds at least two results)
    localparam int QDepth = 4;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [31:0] index;
        t_status     status;
        logic        last;
    } t_result;

    // Results produced by one request, in order; num is 0, 1 or 2
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result mk_result(t_kind kind, logic [63:0] value,
                                          logic [31:0] index, t_status status,
                                          logic last);
        t_result r;
        r.kind   = kind;
        r.value  = value;
        r.index  = index;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sdbi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdbi_if
// Valid/ready channels: file bytes in, parsed results out.
// ----------------------------------------------------------------------------
interface sdbi_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface sdbi_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [63:0] field_value;
    logic [31:0] entry_index;
    logic [2:0]  status_code;
    logic        last_result;

    modport source (output valid, output result_kind, output field_value,
                    output entry_index, output status_code, output last_result,
                    input ready);
    modport sink   (input valid, input result_kind, input field_value,
                    input entry_index, input status_code, input last_result,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/sdbi_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdbi_parser
// Byte-wise header/table parser; produces up to two results per request.
// ----------------------------------------------------------------------------
module sdbi_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_end_of_file,
    output sdbi_pkg::t_push      o_push
);
    import sdbi_pkg::*;

    t_phase      r_phase,        n_phase;
    logic [2:0]  r_byte_cnt,     n_byte_cnt;
    logic [63:0] r_acc,          n_acc;
    logic [31:0] r_str_rem,      n_str_rem;
    logic [1:0]  r_strings_left, n_strings_left;
    logic        r_v5,           n_v5;
    logic        r_ver_ok,       n_ver_ok;
    logic        r_protein,      n_protein;
    logic [31:0] r_seq_count,    n_seq_count;
    logic [31:0] r_word_idx,     n_word_idx;
    logic [31:0] r_first,        n_first;
    logic        r_finished,     n_finished;

    logic [63:0] v;
    logic [31:0] v32;
    logic        field_done;
    logic        in_field;
    logic [1:0]  left_dec;
    logic        seq_last;
    logic [31:0] first_eff;
    t_status     seq_status;
    logic        ends_here;
    logic        in_tables;

    // Field assembly and shared decode
    assign v          = {r_acc[55:0], i_data_byte};
    assign v32        = v[31:0];
    assign field_done = (r_phase == PH_RESIDUES) ? (r_byte_cnt == LAST_BYTE_W8)
                                                 : (r_byte_cnt == LAST_BYTE_W4);
    assign in_field   = !r_finished && (r_phase != PH_STRBODY) && field_done;
    assign left_dec   = (r_strings_left != 2'd0) ? (r_strings_left - 2'd1) : 2'd0;
    assign seq_last   = (r_word_idx == r_seq_count);
    assign first_eff  = (r_word_idx == 32'd0) ? v32 : r_first;
    assign seq_status = ((r_seq_count == 32'd0) || (first_eff >= v32)) ? ST_CORRUPT :
                        (!r_protein ? ST_NOT_PROTEIN : ST_OK);
    assign ends_here  = in_field &&
                        (((r_phase == PH_TYPE) && !r_ver_ok) ||
                         ((r_phase == PH_SEQTAB) && seq_last));
    // phase after this byte lies within the offset tables
    assign in_tables  = (r_phase == PH_HDRTAB) || (r_phase == PH_SEQTAB) ||
                        ((r_phase == PH_MAXLEN) && field_done);

    // Next state
    always_comb begin
        n_phase        = r_phase;
        n_byte_cnt     = r_byte_cnt;
        n_acc          = r_acc;
        n_str_rem      = r_str_rem;
        n_strings_left = r_strings_left;
        n_v5           = r_v5;
        n_ver_ok       = r_ver_ok;
        n_protein      = r_protein;
        n_seq_count    = r_seq_count;
        n_word_idx     = r_word_idx;
        n_first        = r_first;
        n_finished     = r_finished;

        if (i_accept) begin
            if (!r_finished) begin
                if (r_phase == PH_STRBODY) begin
                    n_str_rem = r_str_rem - 32'd1;
                    if (r_str_rem == 32'd1) begin
                        n_strings_left = left_dec;
                        n_phase        = (left_dec != 2'd0) ? PH_STRLEN : PH_COUNT;
                    end
                end else begin
                    n_acc      = v;
                    n_byte_cnt = r_byte_cnt + 3'd1;
                    if (field_done) begin
                        n_acc      = 64'd0;
                        n_byte_cnt = 3'd0;
                        case (r_phase)
                            PH_VERSION: begin
                                n_ver_ok = (v == VERSION_FOUR) || (v == VERSION_FIVE);
                                n_v5     = (v == VERSION_FIVE);
                                n_phase  = PH_TYPE;
                            end
                            PH_TYPE: begin
                                n_protein = (v == TYPE_PROTEIN);
                                if (!r_ver_ok) begin
                                    n_finished = 1'b1;
                                end else begin
                                    n_strings_left = r_v5 ? STRINGS_V5 : STRINGS_V4;
                                    n_phase        = r_v5 ? PH_VOLUME : PH_STRLEN;
                                end
                            end
                            PH_VOLUME: begin
                                n_phase = PH_STRLEN;
                            end
                            PH_STRLEN: begin
                                if (v32 == 32'd0) begin
                                    n_strings_left = left_dec;
                                    n_phase = (left_dec != 2'd0) ? PH_STRLEN : PH_COUNT;
                                end else begin
                                    n_str_rem = v32;
                                    n_phase   = PH_STRBODY;
                                end
                            end
                            PH_COUNT: begin
                                n_seq_count = v32;
                                n_phase     = PH_RESIDUES;
                            end
                            PH_RESIDUES: begin
                                n_phase = PH_MAXLEN;
                            end
                            PH_MAXLEN: begin
                                n_word_idx = 32'd0;
                                n_phase    = PH_HDRTAB;
                            end
                            PH_HDRTAB: begin
                                if (seq_last) begin
                                    n_word_idx = 32'd0;
                                    n_phase    = PH_SEQTAB;
                                end else begin
                                    n_word_idx = r_word_idx + 32'd1;
                                end
                            end
                            PH_SEQTAB: begin
                                if (r_word_idx == 32'd0) begin
                                    n_first = v32;
                                end
                                if (seq_last) begin
                                    n_finished = 1'b1;
                                end else begin
                                    n_word_idx = r_word_idx + 32'd1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            // end of file: back to the start
            if (i_end_of_file) begin
                n_phase        = PH_VERSION;
                n_byte_cnt     = 3'd0;
                n_acc          = 64'd0;
                n_str_rem      = 32'd0;
                n_strings_left = 2'd0;
                n_v5           = 1'b0;
                n_ver_ok       = 1'b0;
                n_protein      = 1'b0;
                n_seq_count    = 32'd0;
                n_word_idx     = 32'd0;
                n_first        = 32'd0;
                n_finished     = 1'b0;
            end
        end
    end

    // Result generation
    always_comb begin
        t_result fr;
        t_result sr;
        logic    fv;
        logic    sv;

        fr = mk_result(KIND_VERSION, 64'd0, 32'd0, ST_OK, 1'b0);
        sr = mk_result(KIND_STATUS, 64'd0, 32'd0, ST_OK, 1'b1);
        fv = 1'b0;
        sv = 1'b0;

        if (i_accept) begin
            if (in_field) begin
                case (r_phase)
                    PH_VERSION: begin
                        fv = 1'b1;
                        fr = mk_result(KIND_VERSION, v, 32'd0, ST_OK, 1'b0);
                    end
                    PH_TYPE: begin
                        if (!r_ver_ok) begin
                            sv = 1'b1;
                            sr = mk_result(KIND_STATUS, 64'd0, 32'd0, ST_BAD_VERSION, 1'b1);
                        end
                    end
                    PH_VOLUME: begin
                        fv = 1'b1;
                        fr = mk_result(KIND_VOLUME, v, 32'd0, ST_OK, 1'b0);
                    end
                    PH_COUNT: begin
                        fv = 1'b1;
                        fr = mk_result(KIND_COUNT, v, 32'd0, ST_OK, 1'b0);
                    end
                    PH_RESIDUES: begin
                        fv = 1'b1;
                        fr = mk_result(KIND_RESIDUES, v, 32'd0, ST_OK, 1'b0);
                    end
                    PH_MAXLEN: begin
                        fv = 1'b1;
                        fr = mk_result(KIND_MAXLEN, v, 32'd0, ST_OK, 1'b0);
                    end
                    PH_SEQTAB: begin
                        fv = 1'b1;
                        fr = mk_result(KIND_OFFSET, v, r_word_idx, ST_OK, 1'b0);
                        if (seq_last) begin
                            sv = 1'b1;
                            sr = mk_result(KIND_STATUS, 64'd0, 32'd0, seq_status, 1'b1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // file ends before the status was given
            if (i_end_of_file && !r_finished && !ends_here) begin
                sv = 1'b1;
                sr = mk_result(KIND_STATUS, 64'd0, 32'd0,
                               in_tables ? ST_TABLES_INC : ST_TRUNC_HDR, 1'b1);
            end
        end

        if (fv) begin
            o_push.r0  = fr;
            o_push.r1  = sr;
            o_push.num = sv ? 2'd2 : 2'd1;
        end else begin
            o_push.r0  = sr;
            o_push.r1  = sr;
            o_push.num = sv ? 2'd1 : 2'd0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_VERSION;
            r_byte_cnt     <= 3'd0;
            r_acc          <= 64'd0;
            r_str_rem      <= 32'd0;
            r_strings_left <= 2'd0;
            r_v5           <= 1'b0;
            r_ver_ok       <= 1'b0;
            r_protein      <= 1'b0;
            r_seq_count    <= 32'd0;
            r_word_idx     <= 32'd0;
            r_first        <= 32'd0;
            r_finished     <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_byte_cnt     <= n_byte_cnt;
            r_acc          <= n_acc;
            r_str_rem      <= n_str_rem;
            r_strings_left <= n_strings_left;
            r_v5           <= n_v5;
            r_ver_ok       <= n_ver_ok;
            r_protein      <= n_protein;
            r_seq_count    <= n_seq_count;
            r_word_idx     <= n_word_idx;
            r_first        <= n_first;
            r_finished     <= n_finished;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sdbi_result_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdbi_result_fifo
// Small result queue: up to two results in a cycle, one out a cycle if popped.
// ----------------------------------------------------------------------------
module sdbi_result_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sdbi_pkg::t_push   i_push,
    input  wire logic              i_pop,
    output logic                   o_room,
    output logic                   o_valid,
    output sdbi_pkg::t_result      o_head
);
    import sdbi_pkg::*;

    localparam int PtrW = $clog2(QDepth);
    localparam int CntW = $clog2(QDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QDepth - 1);
    localparam logic [CntW-1:0] RoomMax = CntW'(QDepth - 2);

    t_result            r_mem [QDepth];
    logic [PtrW-1:0]    r_wptr, n_wptr;
    logic [PtrW-1:0]    r_rptr, n_rptr;
    logic [CntW-1:0]    r_count, n_count;
    logic [PtrW-1:0]    wptr_next;
    logic               do_pop;

    function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
        return (p == PtrLast) ? '0 : (p + PtrW'(1));
    endfunction

    assign wptr_next = ptr_inc(r_wptr);
    assign do_pop    = i_pop && (r_count != '0);
    assign o_room    = (r_count <= RoomMax);
    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rptr];

    // Pointer and fill count update
    always_comb begin
        n_rptr  = do_pop ? ptr_inc(r_rptr) : r_rptr;
        case (i_push.num)
            2'd1:    n_wptr = wptr_next;
            2'd2:    n_wptr = ptr_inc(wptr_next);
            default: n_wptr = r_wptr;
        endcase
        n_count = r_count + CntW'(i_push.num) - CntW'(do_pop);
    end

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wptr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wptr_next] <= i_push.r1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sequence_db_index_parser_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_db_index_parser_core
// Parses a sequence database index file, one byte per request.
// A result enters the registered result queue when its byte is accepted and
// reaches the output once the results ahead of it are taken. Throughput: one
// byte per cycle; a byte is taken while the four-entry result queue has at
// least two free slots, so a slow sink stalls the input once the queue fills.
// Reset: synchronous, active low; parser returns to the version field and the
// result queue empties.
// ----------------------------------------------------------------------------
module sequence_db_index_parser_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sdbi_req_if.sink   i_req,
    sdbi_res_if.source o_res
);
    import sdbi_pkg::*;

    t_push   push;
    t_result head;
    logic    room;
    logic    accept;

    assign i_req.ready = room;
    assign accept      = i_req.valid && room;

    // Parser: state update and result generation
    sdbi_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_req.data_byte),
        .i_end_of_file (i_req.end_of_file),
        .o_push        (push)
    );

    // Result queue
    sdbi_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_res.ready),
        .o_room  (room),
        .o_valid (o_res.valid),
        .o_head  (head)
    );

    // Output payload
    assign o_res.result_kind = head.kind;
    assign o_res.field_value = head.value;
    assign o_res.entry_index = head.index;
    assign o_res.status_code = head.status;
    assign o_res.last_result = head.last;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sequence database index parser. Index files are
// built in memory (well-formed ones of both versions, cut-short ones, bad
// versions, corrupt offset tables and plain noise), streamed one byte per
// request with random gaps, and every result is compared against a cycle-free
// behavioral parser updated as each byte is accepted.
// ----------------------------------------------------------------------------
module tb;
    import sdbi_pkg::*;

    localparam int TotalBytes     = 1000;  // overall request budget
    localparam int MinRandomBytes = 300;   // random files always get this much
    localparam int MaxReports     = 10;
    localparam int HoldStartA     = 400;   // sink hold-off windows, in cycles
    localparam int HoldEndA       = 700;
    localparam int HoldStartB     = 6000;
    localparam int HoldEndB       = 6400;
    localparam int DrainCycles    = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_byte_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sdbi_req_if byte_ch ();
    sdbi_res_if result_ch ();

    sequence_db_index_parser_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (byte_ch),
        .o_res   (result_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral parser state
    // ------------------------------------------------------------------------
    t_phase      cur_phase;
    logic [31:0] field_bytes;
    logic [63:0] field_shift;
    logic        ver5;
    logic        ver_good;
    logic        protein;
    logic [31:0] seq_count;
    logic [33:0] word_pos;
    logic [31:0] first_ofs;
    logic        file_done;
    logic [1:0]  strings_togo;

    t_result     pending_results[$];

    // Stimulus and bookkeeping
    t_byte_req   bytes_to_send[$];
    logic [7:0]  file_img[$];
    int          header_len;
    int          bytes_queued   = 0;
    int          files_queued   = 0;
    int          bytes_taken    = 0;
    int          results_seen   = 0;
    int          offsets_seen   = 0;
    int          statuses_seen  = 0;
    int          mismatches     = 0;

    // Driver / sink pacing
    t_byte_req   next_byte;
    int          send_gap    = 0;
    logic        src_gappy   = 1'b1;
    int          sink_wait   = 0;
    logic        sink_gappy  = 1'b1;
    logic        sink_hold   = 1'b0;
    int          run_cycles  = 0;

    task automatic restart_parse();
        cur_phase    = PH_VERSION;
        field_bytes  = '0;
        field_shift  = '0;
        ver5         = 1'b0;
        ver_good     = 1'b0;
        protein      = 1'b0;
        seq_count    = '0;
        word_pos     = '0;
        first_ofs    = '0;
        file_done    = 1'b0;
        strings_togo = '0;
    endtask

    function automatic void push_result(t_kind kind, logic [63:0] value,
                                        logic [31:0] idx, t_status st, logic last);
        t_result r;
        r.kind   = kind;
        r.value  = value;
        r.index  = idx;
        r.status = st;
        r.last   = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic end_string();
        if (strings_togo != 0) strings_togo = strings_togo - 1'b1;
        cur_phase = (strings_togo != 0) ? PH_STRLEN : PH_COUNT;
    endtask

    // Advance the parser by one accepted byte and queue what it produces
    task automatic parse_byte(input logic [7:0] b, input logic eof);
        logic [63:0] v;
        logic [63:0] words;
        logic [31:0] idx;
        t_status     st;
        if (!file_done) begin
            if (cur_phase == PH_STRBODY) begin
                if (field_bytes != 0) field_bytes = field_bytes - 1;
                if (field_bytes == 0) end_string();
            end else begin
                field_shift = {field_shift[55:0], b};
                field_bytes = field_bytes + 1;
                if (field_bytes >= ((cur_phase == PH_RESIDUES) ? 32'd8 : 32'd4)) begin
                    v           = field_shift;
                    words       = {32'd0, seq_count} + 64'd1;   // no 32-bit wrap
                    field_bytes = '0;
                    field_shift = '0;
                    case (cur_phase)
                        PH_VERSION: begin
                            push_result(KIND_VERSION, v, 32'd0, ST_OK, 1'b0);
                            ver_good  = (v == VERSION_FOUR) || (v == VERSION_FIVE);
                            ver5      = (v == VERSION_FIVE);
                            cur_phase = PH_TYPE;
                        end
                        PH_TYPE: begin
                            protein = (v == TYPE_PROTEIN);
                            if (!ver_good) begin
                                push_result(KIND_STATUS, 64'd0, 32'd0, ST_BAD_VERSION, 1'b1);
                                file_done = 1'b1;
                            end else begin
                                strings_togo = ver5 ? STRINGS_V5 : STRINGS_V4;
                                cur_phase    = ver5 ? PH_VOLUME : PH_STRLEN;
                            end
                        end
                        PH_VOLUME: begin
                            push_result(KIND_VOLUME, v, 32'd0, ST_OK, 1'b0);
                            cur_phase = PH_STRLEN;
                        end
                        PH_STRLEN: begin
                            if (v == 64'd0) begin
                                end_string();
                            end else begin
                                field_bytes = v[31:0];
                                cur_phase   = PH_STRBODY;
                            end
                        end
                        PH_COUNT: begin
                            seq_count = v[31:0];
                            push_result(KIND_COUNT, v, 32'd0, ST_OK, 1'b0);
                            cur_phase = PH_RESIDUES;
                        end
                        PH_RESIDUES: begin
                            push_result(KIND_RESIDUES, v, 32'd0, ST_OK, 1'b0);
                            cur_phase = PH_MAXLEN;
                        end
                        PH_MAXLEN: begin
                            push_result(KIND_MAXLEN, v, 32'd0, ST_OK, 1'b0);
                            word_pos  = '0;
                            cur_phase = PH_HDRTAB;
                        end
                        PH_HDRTAB: begin
                            word_pos = word_pos + 1'b1;
                            if (64'(word_pos) >= words) cur_phase = PH_SEQTAB;
                        end
                        default: begin
                            // sequence offset table
                            idx = 32'(64'(word_pos) - words);
                            push_result(KIND_OFFSET, v, idx, ST_OK, 1'b0);
                            if (idx == 32'd0) first_ofs = v[31:0];
                            word_pos = word_pos + 1'b1;
                            if (64'(word_pos) >= (words << 1)) begin
                                // corrupt offsets take precedence over type
                                if (seq_count == 32'd0 || {32'd0, first_ofs} >= v)
                                    st = ST_CORRUPT;
                                else if (!protein)
                                    st = ST_NOT_PROTEIN;
                                else
                                    st = ST_OK;
                                push_result(KIND_STATUS, 64'd0, 32'd0, st, 1'b1);
                                file_done = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
        if (eof) begin
            if (!file_done) begin
                st = (cur_phase <= PH_MAXLEN) ? ST_TRUNC_HDR : ST_TABLES_INC;
                push_result(KIND_STATUS, 64'd0, 32'd0, st, 1'b1);
            end
            restart_parse();
        end
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= MaxReports) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result();
        t_result got;
        t_result want;
        got.kind   = t_kind'(result_ch.result_kind);
        got.value  = result_ch.field_value;
        got.index  = result_ch.entry_index;
        got.status = t_status'(result_ch.status_code);
        got.last   = result_ch.last_result;
        results_seen++;
        if (got.kind == KIND_OFFSET) offsets_seen++;
        if (got.kind == KIND_STATUS) statuses_seen++;
        if (pending_results.size() == 0) begin
            report_error($sformatf({"unexpected result kind=%0d value=%h index=%0d ",
                                    "status=%0d last=%0d"},
                                   got.kind, got.value, got.index, got.status, got.last));
        end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.index !== want.index || got.status !== want.status ||
                got.last !== want.last) begin
                report_error($sformatf({"result %0d: expected kind=%0d value=%h index=%0d ",
                                        "status=%0d last=%0d, got kind=%0d value=%h index=%0d ",
                                        "status=%0d last=%0d"},
                                       results_seen, want.kind, want.value, want.index,
                                       want.status, want.last, got.kind, got.value,
                                       got.index, got.status, got.last));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // File image builders
    // ------------------------------------------------------------------------
    task automatic put_word32(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) file_img.insert(file_img.size(), w[8*i +: 8]);
    endtask

    task automatic put_word64(input logic [63:0] w);
        put_word32(w[63:32]);
        put_word32(w[31:0]);
    endtask

    task automatic build_header(input logic [31:0] ver, input logic [31:0] ftype,
                                input logic [31:0] count, input logic [63:0] residues,
                                input logic [31:0] maxlen);
        int n_str;
        int slen;
        file_img.delete();
        put_word32(ver);
        put_word32(ftype);
        if (ver == VERSION_FIVE[31:0]) put_word32($urandom);
        n_str = (ver == VERSION_FIVE[31:0]) ? int'(STRINGS_V5) : int'(STRINGS_V4);
        repeat (n_str) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: slen = 0;
                4:          slen = $urandom_range(7, 300);
                default:    slen = $urandom_range(1, 6);
            endcase
            put_word32(slen);
            repeat (slen) file_img.insert(file_img.size(), 8'($urandom));
        end
        put_word32(count);
        put_word64(residues);
        put_word32(maxlen);
        header_len = file_img.size();
    endtask

    // Header offset table (skipped), then count+1 sequence offsets from lo to hi
    task automatic build_tables(input int count, input logic [31:0] lo, input logic [31:0] hi);
        repeat (count + 1) put_word32($urandom);
        put_word32(lo);
        if (count > 0) begin
            repeat (count - 1) put_word32($urandom);
            put_word32(hi);
        end
    endtask

    // Queue the first cut bytes of the image; past its end, pad with junk
    task automatic send_file(input int cut);
        t_byte_req r;
        for (int i = 0; i < cut; i++) begin
            r.data = (i < file_img.size()) ? file_img[i] : 8'($urandom);
            r.eof  = (i == cut - 1);
            bytes_to_send.insert(bytes_to_send.size(), r);
        end
        bytes_queued += cut;
        files_queued++;
    endtask

    // ------------------------------------------------------------------------
    // Byte driver: accepted requests feed the parser model
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                parse_byte(byte_ch.data_byte, byte_ch.end_of_file);
                bytes_taken++;
            end
            if (byte_ch.valid && !byte_ch.ready) begin
                // request stalled, hold it
            end else if (send_gap > 0) begin
                send_gap--;
                byte_ch.valid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
                next_byte = bytes_to_send.pop_front();
                byte_ch.valid       <= 1'b1;
                byte_ch.data_byte   <= next_byte.data;
                byte_ch.end_of_file <= next_byte.eof;
                if ($urandom_range(0, 63) == 0) src_gappy = !src_gappy;
                send_gap = src_gappy ? $urandom_range(0, 15) : 0;
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor with random backpressure
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                check_result();
                if ($urandom_range(0, 63) == 0) sink_gappy = !sink_gappy;
                sink_wait = sink_gappy ? $urandom_range(0, 15) : 0;
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            result_ch.ready <= (sink_wait == 0) && !sink_hold;
        end
    end

    // Long sink hold-offs so the result queue fills and the input stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_cycles <= 0;
            sink_hold  <= 1'b0;
        end else begin
            run_cycles <= run_cycles + 1;
            sink_hold  <= (run_cycles >= HoldStartA && run_cycles < HoldEndA) ||
                          (run_cycles >= HoldStartB && run_cycles < HoldEndB);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] ver;
        logic [31:0] ftype;
        logic [31:0] lo;
        logic [31:0] hi;
        int          count;
        int          pick;
        int          directed_bytes;
        int          directed_files;

        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'd0;
        byte_ch.end_of_file = 1'b0;
        result_ch.ready     = 1'b0;
        restart_parse();

        // v4, extreme offsets: end inside version, end inside type, then whole
        build_header(VERSION_FOUR[31:0], TYPE_PROTEIN[31:0], 32'd1, 64'd0, 32'd0);
        build_tables(1, 32'd0, 32'hFFFF_FFFF);
        send_file(1);
        send_file(6);
        send_file(file_img.size());

        // v5, all-ones residues and longest length, cut at each region boundary
        build_header(VERSION_FIVE[31:0], TYPE_PROTEIN[31:0], 32'd3, '1, '1);
        build_tables(3, 32'd10, 32'd20);
        send_file(header_len - 16);             // last byte of the strings
        send_file(header_len - 12);             // last byte of count
        send_file(header_len);                  // last byte of longest length
        send_file(header_len + 16);             // last byte of header offsets
        send_file(file_img.size() - 3);         // inside sequence offsets
        send_file(file_img.size() + 3);         // complete, trailing bytes

        // bad versions: trailing bytes ignored; end right on or inside the type field
        build_header(32'd3, TYPE_PROTEIN[31:0], 32'd2, 64'd1, 32'd1);
        build_tables(2, 32'd1, 32'd2);
        send_file(file_img.size() + 4);
        build_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 64'd0, 32'd0);
        send_file(8);
        build_header(32'd0, 32'd0, 32'd1, 64'd0, 32'd0);
        send_file(7);

        // single offset entry
        build_header(VERSION_FIVE[31:0], TYPE_PROTEIN[31:0], 32'd0, 64'd9, 32'd9);
        build_tables(0, 32'd7, 32'd7);
        send_file(file_img.size());

        // equal first and last on a non-protein file: corrupt wins
        build_header(VERSION_FOUR[31:0], 32'd2, 32'd2, {$urandom, $urandom}, $urandom);
        build_tables(2, 32'd100, 32'd100);
        send_file(file_img.size());

        // last offset below first
        build_header(VERSION_FOUR[31:0], TYPE_PROTEIN[31:0], 32'd4, 64'd77, 32'd3);
        build_tables(4, 32'd500, 32'd499);
        send_file(file_img.size());

        // well-ordered but not protein
        build_header(VERSION_FIVE[31:0], 32'd0, 32'd2, 64'd12, 32'd4);
        build_tables(2, 32'd1, 32'd2);
        send_file(file_img.size());

        // all-ones count: tables never finish, count+1 must not wrap to zero
        build_header(VERSION_FIVE[31:0], TYPE_PROTEIN[31:0], 32'hFFFF_FFFF, 64'd5, 32'd5);
        repeat (6) put_word32($urandom);
        send_file(file_img.size());

        directed_bytes = bytes_queued;
        directed_files = files_queued;

        // Random files: mostly well-formed, some cut short, bad versions, noise
        while (bytes_queued < TotalBytes ||
               bytes_queued < directed_bytes + MinRandomBytes) begin
            pick  = $urandom_range(0, 99);
            ver   = $urandom_range(0, 1) ? VERSION_FIVE[31:0] : VERSION_FOUR[31:0];
            ftype = ($urandom_range(0, 7) == 0) ? $urandom : TYPE_PROTEIN[31:0];
            count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            if (pick >= 85 && pick < 95) begin
                ver = $urandom;
                if (ver == VERSION_FOUR[31:0] || ver == VERSION_FIVE[31:0]) ver = 32'd6;
            end
            lo = $urandom_range(0, 32'h7FFF_FFFF);
            case ($urandom_range(0, 9))
                0: hi = lo;
                1: begin
                    hi = lo;
                    lo = hi + 1 + $urandom_range(0, 32'h7FFF_FFFE);
                end
                default: hi = lo + 1 + $urandom_range(0, 32'h7FFF_FFFE);
            endcase
            build_header(ver, ftype, count, {$urandom, $urandom}, $urandom);
            build_tables(count, lo, hi);
            if (pick < 70) begin
                send_file(file_img.size() +
                          (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0));
            end else if (pick < 95) begin
                send_file($urandom_range(1, file_img.size()));
            end else begin
                file_img.delete();
                repeat ($urandom_range(1, 20)) file_img.insert(file_img.size(), 8'($urandom));
                send_file(file_img.size());
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != bytes_queued) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Covered %0d files (%0d directed), %0d bytes; %0d results checked",
                 files_queued, directed_files, bytes_taken, results_seen);
        $display("  including %0d sequence offsets and %0d file status results, %0d mismatches",
                 offsets_seen, statuses_seen, mismatches);
        if (mismatches == 0) begin
            $display("sequence_db_index_parser_core test passed");
        end else begin
            $display("sequence_db_index_parser_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("sequence_db_index_parser_core test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sdbi_pkg.sv
rtl/sdbi_if.sv
rtl/sdbi_parser.sv
rtl/sdbi_result_fifo.sv
rtl/sequence_db_index_parser_core.sv
tb/tb.sv
